// ===== rtl/q32_32_fixed_point_alu_defines.svh =====
// Assertion macros for the Q32.32 arithmetic unit
`ifndef Q32_32_FIXED_POINT_ALU_DEFINES_SVH
`define Q32_32_FIXED_POINT_ALU_DEFINES_SVH
// assert that an antecedent implies a consequent in the next cycle
`define Q32_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
// assert that an expression holds at every clock edge
`define Q32_ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`endif

// ===== rtl/q32_pkg.sv =====
// ----------------------------------------------------------------------------
// q32_pkg
// Shared types and codes for the Q32.32 arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none
package q32_pkg;
   localparam int unsigned WordBits = 64;
   localparam int unsigned DivSteps = 64;
   localparam int unsigned SqrtSteps = 28;
   localparam logic [63:0] SqStart = 64'h4000000000000000;
   localparam logic [63:0] LowMask = 64'h00000000FFFFFFFF;

   typedef enum logic [3:0] {
      OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3, OP_MOD = 4'd4,
      OP_SQRT = 4'd5, OP_FLOOR = 4'd6, OP_CEIL = 4'd7, OP_FRACT = 4'd8,
      OP_ROUND = 4'd9, OP_MIN = 4'd10, OP_MAX = 4'd11, OP_CMP = 4'd12,
      OP_ABS = 4'd13, OP_NEG = 4'd14, OP_NONE = 4'd15
   } op_type;

   typedef enum logic [1:0] {
      ST_OK = 2'd0, ST_DIVZERO = 2'd1, ST_OVERFLOW = 2'd2, ST_NEGSQRT = 2'd3
   } status_type;

   typedef struct packed {
      logic [3:0] operation;
      logic signed [63:0] operand_a;
      logic signed [63:0] operand_b;
   } req_type;

   typedef struct packed {
      logic signed [63:0] result_value;
      logic [1:0] status;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic load;      // capture request, do setup
      logic mul_step;  // one partial product phase
      logic div_step;  // one restoring division bit
      logic sqrt_step; // one sqrt iteration
      logic finish;    // form result
   } dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic is_mul;
      logic is_div;   // div or mod, iterative
      logic is_sqrt;
      logic early;    // error status set at load
   } dp_status_type;
endpackage
`default_nettype wire

// ===== rtl/q32_datapath.sv =====
// ----------------------------------------------------------------------------
// q32_datapath
// Operand registers, division subtractor, sqrt compare, multiplier phases, result forming.
// ----------------------------------------------------------------------------
`default_nettype none
module q32_datapath (
   input  wire logic               clock,
   input  wire q32_pkg::req_type       req_data,
   input  wire q32_pkg::dp_cmd_type    cmd,
   output q32_pkg::dp_status_type      stat,
   output q32_pkg::rsp_type            rsp_data
);
   import q32_pkg::*;

   logic [3:0]  op_ff;
   logic [63:0] a_ff, b_ff, ma_ff, mb_ff;
   logic        neg_ff;       // result sign
   logic [1:0]  err_ff;       // early status
   logic [63:0] rem_ff, lo_ff, quo_ff, bit_ff;
   logic [63:0] acc_ff;       // mul accumulator
   logic [1:0]  mph_ff;       // mul phase
   logic [63:0] prod_ff;      // registered partial product
   logic        pvld_ff;
   logic [63:0] simple_ff;    // simple-op results
   rsp_type     rsp_ff;

   logic [63:0] a_in, b_in, ma_in, mb_in;
   logic        alt;
   logic [64:0] rem_sh;
   logic [64:0] diff;
   logic [63:0] sq_t, sq_diff;
   logic        sq_ge;
   logic [31:0] m_x, m_y;
   logic [63:0] m_p;
   logic [63:0] simple_in;
   logic        gt;
   logic [63:0] q_signed, mod_r;

   function automatic logic [63:0] mag(input logic [63:0] x);
      mag = x[63] ? (64'd0 - x) : x;
   endfunction

   assign a_in  = req_data.operand_a;
   assign b_in  = req_data.operand_b;
   assign ma_in = mag(a_in);
   assign mb_in = mag(b_in);
   assign gt    = $signed(a_in) > $signed(b_in);

   always_comb begin
      case (op_type'(req_data.operation))
         OP_ADD:   simple_in = a_in + b_in;
         OP_SUB:   simple_in = a_in - b_in;
         OP_FLOOR: simple_in = a_in & ~LowMask;
         OP_CEIL:  simple_in = (a_in + LowMask) & ~LowMask;
         OP_FRACT: simple_in = a_in & LowMask;
         OP_ROUND: simple_in = (a_in + 64'h80000000) & ~LowMask;
         OP_MIN:   simple_in = gt ? b_in : a_in;
         OP_MAX:   simple_in = gt ? a_in : b_in;
         OP_CMP:   simple_in = gt ? 64'd1 : ((a_in == b_in) ? 64'd0 : '1);
         OP_ABS:   simple_in = ma_in;
         OP_NEG:   simple_in = 64'd0 - a_in;
         default:  simple_in = 64'd0;
      endcase
   end

   // division subtractor: compare/subtract
   assign rem_sh = {rem_ff, lo_ff[63]};
   assign diff   = rem_sh - {1'b0, mb_ff};
   // sqrt compare
   assign sq_t    = quo_ff + bit_ff;
   assign sq_ge   = rem_ff >= sq_t;
   assign sq_diff = rem_ff - sq_t;

   // 32x32 partial products, phase selects halves
   always_comb begin
      unique case (mph_ff)
         2'd0:    begin m_x = ma_ff[63:32]; m_y = mb_ff[63:32]; end
         2'd1:    begin m_x = ma_ff[63:32]; m_y = mb_ff[31:0];  end
         2'd2:    begin m_x = ma_ff[31:0];  m_y = mb_ff[63:32]; end
         default: begin m_x = ma_ff[31:0];  m_y = mb_ff[31:0];  end
      endcase
      m_p = 64'(m_x) * 64'(m_y);
   end

   assign alt = (op_type'(op_ff) == OP_MOD) ? a_ff[63] : (a_ff[63] ^ b_ff[63]);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= req_data.operation;
         a_ff   <= a_in;
         b_ff   <= b_in;
         ma_ff  <= ma_in;
         mb_ff  <= (op_type'(req_data.operation) == OP_MOD) ? b_in : mb_in;
         simple_ff <= simple_in;
         acc_ff <= '0;
         mph_ff <= 2'd0;
         pvld_ff <= 1'b0;
         quo_ff <= '0;
         bit_ff <= SqStart;
         err_ff <= ST_OK;
         if (op_type'(req_data.operation) == OP_SQRT) begin
            rem_ff <= a_in;
            if (a_in[63]) err_ff <= ST_NEGSQRT;
         end else if (op_type'(req_data.operation) == OP_MOD) begin
            rem_ff <= '0;
            lo_ff  <= ma_in;
            if (b_in == 64'd0 || b_in[63]) err_ff <= ST_DIVZERO;
         end else begin
            rem_ff <= {32'd0, ma_in[63:32]};
            lo_ff  <= {ma_in[31:0], 32'd0};
            if (op_type'(req_data.operation) == OP_DIV) begin
               if (b_in == 64'd0) err_ff <= ST_DIVZERO;
               else if ({32'd0, ma_in[63:32]} >= mb_in) err_ff <= ST_OVERFLOW;
            end
         end
      end
      if (cmd.mul_step) begin
         prod_ff <= m_p;
         pvld_ff <= 1'b1;
         mph_ff  <= mph_ff + 2'd1;
         if (pvld_ff) begin
            unique case (mph_ff)
               2'd1:    acc_ff <= acc_ff + {prod_ff[31:0], 32'd0};
               2'd0:    acc_ff <= acc_ff + {32'd0, prod_ff[63:32]};
               default: acc_ff <= acc_ff + prod_ff;
            endcase
         end
      end
      if (cmd.div_step) begin
         lo_ff  <= {lo_ff[62:0], 1'b0};
         if (!diff[64]) begin
            rem_ff <= diff[63:0];
            quo_ff <= {quo_ff[62:0], 1'b1};
         end else begin
            rem_ff <= rem_sh[63:0];
            quo_ff <= {quo_ff[62:0], 1'b0};
         end
      end
      if (cmd.sqrt_step) begin
         // one recurrence step: root grows by twice the bit when the compare passes, remainder doubles
         bit_ff <= {1'b0, bit_ff[63:1]};
         if (sq_ge) begin
            rem_ff <= {sq_diff[62:0], 1'b0};
            quo_ff <= sq_t + bit_ff;
         end else begin
            rem_ff <= {rem_ff[62:0], 1'b0};
         end
      end
      if (cmd.finish) begin
         rsp_ff.status <= err_ff;
         rsp_ff.result_value <= '0;
         if (err_ff == ST_OK) begin
            unique case (op_type'(op_ff))
               OP_MUL:  rsp_ff.result_value <= alt ? (64'd0 - acc_ff) : acc_ff;
               OP_DIV:  begin
                  if (quo_ff[63]) rsp_ff.status <= ST_OVERFLOW;
                  else rsp_ff.result_value <= q_signed;
               end
               OP_MOD:  rsp_ff.result_value <= mod_r;
               OP_SQRT: rsp_ff.result_value <= {16'd0, quo_ff[63:16]};
               default: rsp_ff.result_value <= simple_ff;
            endcase
         end
      end
   end

   assign q_signed = alt ? (64'd0 - quo_ff) : quo_ff;
   assign mod_r    = alt ? (64'd0 - rem_ff) : rem_ff;

   assign stat.is_mul  = op_type'(op_ff) == OP_MUL;
   assign stat.is_div  = op_type'(op_ff) == OP_DIV || op_type'(op_ff) == OP_MOD;
   assign stat.is_sqrt = op_type'(op_ff) == OP_SQRT;
   assign stat.early   = err_ff != ST_OK;
   assign rsp_data     = rsp_ff;
endmodule
`default_nettype wire

// ===== rtl/q32_controller.sv =====
// ----------------------------------------------------------------------------
// q32_controller
// Sequences setup, iterations and result strobe.
// ----------------------------------------------------------------------------
`default_nettype none
module q32_controller (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire q32_pkg::dp_status_type stat,
   output q32_pkg::dp_cmd_type        cmd,
   output logic                       busy,
   output logic                       rsp_valid
);
   import q32_pkg::*;

   typedef enum logic [2:0] {S_IDLE, S_DECODE, S_MUL, S_DIV, S_SQRT, S_FINISH} state_type;

   state_type  state_ff;
   logic [6:0] cnt_ff;
   logic       valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: if (start && !valid_ff) state_ff <= S_DECODE;
            S_DECODE: begin
               cnt_ff <= '0;
               if (stat.early) state_ff <= S_FINISH;
               else if (stat.is_mul) state_ff <= S_MUL;
               else if (stat.is_div) state_ff <= S_DIV;
               else if (stat.is_sqrt) state_ff <= S_SQRT;
               else state_ff <= S_FINISH;
            end
            S_MUL: begin
               cnt_ff <= cnt_ff + 7'd1;
               if (cnt_ff == 7'd4) state_ff <= S_FINISH;
            end
            S_DIV: begin
               cnt_ff <= cnt_ff + 7'd1;
               if (cnt_ff == 7'(DivSteps - 1)) state_ff <= S_FINISH;
            end
            S_SQRT: begin
               cnt_ff <= cnt_ff + 7'd1;
               if (cnt_ff == 7'(2 * SqrtSteps - 1)) state_ff <= S_FINISH;
            end
            S_FINISH: begin
               valid_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy           = state_ff != S_IDLE || valid_ff;
   assign cmd.load       = state_ff == S_IDLE && start && !valid_ff;
   assign cmd.mul_step   = state_ff == S_MUL;
   assign cmd.div_step   = state_ff == S_DIV;
   assign cmd.sqrt_step  = state_ff == S_SQRT;
   assign cmd.finish     = state_ff == S_FINISH;
   assign rsp_valid      = valid_ff;
endmodule
`default_nettype wire

// ===== rtl/q32_32_fixed_point_alu.sv =====
// Sequence: start is loaded in idle, then decode, then the mul, div/mod or sqrt iteration
// state (sqrt: 56 iterations of the sqrt compare/subtract, one per cycle), then finish
// and the result strobe; simple ops and early errors skip iteration. One transaction at
// a time; busy covers the strobe cycle, so the next start is taken the cycle after rsp_valid.
// Reset clears the controller only; no clearing pass. The receiver cannot stall.
`default_nettype none
`include "q32_32_fixed_point_alu_defines.svh"
// ----------------------------------------------------------------------------
// q32_32_fixed_point_alu
// Signed Q32.32 arithmetic unit: controller plus datapath.
// ----------------------------------------------------------------------------
module q32_32_fixed_point_alu (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire q32_pkg::req_type req_data,
   output logic                  rsp_valid,
   output q32_pkg::rsp_type      rsp_data
);
   import q32_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type stat;

   // controller: start accepted when not busy
   q32_controller u_ctrl (
      .clock(clock), .reset(reset), .start(start), .stat(stat),
      .cmd(cmd), .busy(busy), .rsp_valid(rsp_valid)
   );

   // datapath: operands, division subtractor, 32x32 multiplier
   q32_datapath u_dp (
      .clock(clock), .req_data(req_data), .cmd(cmd), .stat(stat), .rsp_data(rsp_data)
   );

   // an accepted transaction must raise busy next cycle
   `Q32_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy, "busy not set")
   // the result strobe is a single pulse
   `Q32_ASSERT_NEXT(a_strobe_pulse, clock, reset, rsp_valid, !rsp_valid, "strobe held")
   // no load command while a result is being strobed
   `Q32_ASSERT_ALWAYS(a_no_load_strobe, clock, reset, !(cmd.load && rsp_valid), "load in strobe")
endmodule
`default_nettype wire
